>>> rtl/core/measurement_clock_rate_tracker_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the measurement clock rate tracker
// ---------------------------------------------------------------------------
`ifndef MEASUREMENT_CLOCK_RATE_TRACKER_UNIT_DEFINES_SVH
`define MEASUREMENT_CLOCK_RATE_TRACKER_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define MCRT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define MCRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/mcrt_pkg.sv
// ---------------------------------------------------------------------------
// mcrt_pkg
// Shared types and constants of the measurement clock rate tracker.
// ---------------------------------------------------------------------------
package mcrt_pkg;
   localparam int unsigned SampleDepth = 5;
   localparam int unsigned IdxW = $clog2(SampleDepth);
   localparam int unsigned CntW = $clog2(SampleDepth + 1);
   localparam logic [31:0] OneQ22 = 32'd4194304;

   localparam logic [1:0] KIND_OBSERVE = 2'd0;
   localparam logic [1:0] KIND_STALL   = 2'd1;
   localparam logic [1:0] KIND_RESOLVE = 2'd2;
   localparam logic [1:0] KIND_RESET   = 2'd3;

   localparam logic [2:0] CSR_REORDER  = 3'd0;
   localparam logic [2:0] CSR_INTERVAL = 3'd1;
   localparam logic [2:0] CSR_MIN_RATE = 3'd2;
   localparam logic [2:0] CSR_MAX_RATE = 3'd3;
   localparam logic [2:0] CSR_STALL_TO = 3'd4;

   // Divider request and reply.
   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic        ok;
      logic [31:0] quo;
   } div_rsp_type;
endpackage

>>> rtl/core/mcrt_divider.sv
// ---------------------------------------------------------------------------
// mcrt_divider
// Serial restoring divider: floor(num * 2^22 / den), one bit per cycle.
// ---------------------------------------------------------------------------
module mcrt_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  mcrt_pkg::div_req_type req,
   output mcrt_pkg::div_rsp_type rsp
);
   import mcrt_pkg::*;

   // 86-bit dividend walked one bit per step; remainder kept 65 bits wide.
   logic        busy_ff, busy_in;
   logic [6:0]  step_ff, step_in;
   logic [85:0] dvd_ff, dvd_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [85:0] quo_ff, quo_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      trial   = {rem_ff[63:0], dvd_ff[85]};
      if (req.start) begin
         busy_in = 1'b1;
         step_in = 7'd0;
         dvd_in  = {req.num, 22'd0};
         rem_in  = '0;
         den_in  = req.den;
         quo_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[84:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[84:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[84:0], 1'b0};
         end
         step_in = step_ff + 7'd1;
         if (step_ff == 7'd85) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.ok   = (den_ff != 64'd0) && (quo_ff[85:32] == '0);
   assign rsp.quo  = quo_ff[31:0];
endmodule

>>> rtl/core/measurement_clock_rate_tracker_unit.sv
// ---------------------------------------------------------------------------
// measurement_clock_rate_tracker_unit
// Tracks a remote measurement clock against local time and resolves stamps.
// ---------------------------------------------------------------------------
// Usage:
// A request is taken when start is high and busy is low. req_kind picks
// observe, stall check, resolve or reset. Exactly one response follows, shown
// for one cycle with rsp_strobe high; the receiver cannot stall it.
// Registers are written via csr_valid/csr_ready with csr_index and csr_wdata;
// csr_ready is always high; the user must write only while idle (unchecked).
// Stall check, reset, dropped observes and observes that take no sample
// pass from EVAL to RESP; the response is registered out of RESP.
// An observe that reaches a rate sample runs the serial divider (86 steps)
// and goes to RESP when the sample is rejected; an accepted sample adds a
// serial sort over the buffer and a median step (SORT, MED) before RESP.
// A resolve that maps a stamp runs two 32x32 partial products, then SCALE.
// One request is in flight at a time; busy stays high until the response.
// Reset clears the tracking state and loads register defaults.
// ---------------------------------------------------------------------------
`include "measurement_clock_rate_tracker_unit_defines.svh"

module measurement_clock_rate_tracker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_measurement_ns,
   input  logic [63:0] req_sim_real_ns,
   input  logic signed [63:0] req_monotonic_ns,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output logic        rsp_strobe,
   output logic [63:0] rsp_stamp_measurement_ns,
   output logic signed [63:0] rsp_capture_monotonic_ns,
   output logic        rsp_clock_valid,
   output logic [31:0] rsp_reset_count,
   output logic        rsp_stall_detected,
   output logic        rsp_observation_taken,
   output logic [63:0] rsp_clock_now_ns,
   output logic signed [63:0] rsp_last_arrival_ns,
   output logic [31:0] rsp_rate_q22
);
   import mcrt_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_EVAL   = 4'd1;
   localparam logic [3:0] ST_DIV    = 4'd2;
   localparam logic [3:0] ST_SORT   = 4'd3;
   localparam logic [3:0] ST_MED    = 4'd4;
   localparam logic [3:0] ST_MUL    = 4'd5;
   localparam logic [3:0] ST_SCALE  = 4'd6;
   localparam logic [3:0] ST_RESP   = 4'd7;

   logic [3:0]  state_ff, state_in;

   logic [31:0] reorder_ff, interval_ff, minr_ff, maxr_ff;
   logic [62:0] stallto_ff;

   logic [1:0]  kind_ff;
   logic [63:0] m_ff, real_ff, mono_ff;

   logic [63:0] refm_ff, refm_in, refa_ff, refa_in;
   logic [63:0] segm_ff, segm_in, segr_ff, segr_in, segmono_ff, segmono_in;
   logic [31:0] samp_ff [SampleDepth];
   logic [31:0] samp_in [SampleDepth];
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [IdxW-1:0] cur_ff, cur_in;
   logic [31:0] med_ff, med_in, resets_ff, resets_in;
   logic        fvalid_ff, fvalid_in, frate_ff, frate_in;
   logic        freal_ff, freal_in, fstall_ff, fstall_in;

   // Sort buffer and shared compare/swap position.
   logic [31:0] srt_ff [SampleDepth];
   logic [31:0] srt_in [SampleDepth];
   logic [IdxW-1:0] spos_ff, spos_in;
   logic [CntW-1:0] spass_ff, spass_in;

   // Resolve datapath.
   logic [63:0] stamp_ff, stamp_in, cap_ff, cap_in, d_ff, d_in;
   logic        fwd_ff, fwd_in;
   logic [63:0] plo_ff, plo_in, phi_ff, phi_in;
   logic [1:0]  mstep_ff, mstep_in;

   logic        stall_out_ff, stall_out_in, taken_ff, taken_in;
   logic        strobe_ff, strobe_in;

   div_req_type dreq;
   div_rsp_type drsp;
   logic [63:0] div_num, div_den;

   mcrt_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   logic        accept;
   assign accept = start && !busy;

   // Evaluation helpers.
   logic        uses, rewound, drop, new_seg, chk_stall;
   logic [63:0] md, rd;
   logic [31:0] rate_sel, s0, s1;
   logic [32:0] med_sum;
   logic [63:0] a_val, b_val, lim_val, s_val;
   logic [64:0] ab_sum;
   logic        sat;
   logic [63:0] mono_diff;
   logic [CntW-1:0] nsort;

   always_comb begin
      uses    = real_ff != 64'd0;
      rewound = fvalid_ff && (m_ff < refm_ff);
      drop    = 1'b0;
      if (fvalid_ff) begin
         if (m_ff == refm_ff) drop = 1'b1;
         else if (m_ff < refm_ff) drop = (refm_ff - m_ff) <= {32'd0, reorder_ff};
         else drop = $signed(mono_ff) <= $signed(refa_ff);
      end
      new_seg = !fvalid_ff || fstall_ff || rewound || (uses != freal_ff)
                || (uses && real_ff <= segr_ff);
      md = m_ff - segm_ff;
      rd = uses ? real_ff - segr_ff
                : (($signed(mono_ff) >= $signed(segmono_ff)) ? mono_ff - segmono_ff : 64'd0);
      mono_diff = mono_ff - refa_ff;
      chk_stall = fvalid_ff && !fstall_ff && (stallto_ff != 63'd0)
                  && ($signed(mono_ff) > $signed(refa_ff))
                  && (mono_diff > {1'b0, stallto_ff});
      rate_sel = frate_ff ? med_ff : OneQ22;
      nsort = cnt_ff;
      s0 = srt_ff[IdxW'((nsort >> 1) - CntW'(1))];
      s1 = srt_ff[IdxW'(nsort >> 1)];
      med_sum = {1'b0, s0} + {1'b0, s1};
      // Scale combine: phi holds hi*rate, plo holds lo*rate + half.
      sat    = phi_ff[63:54] != 10'd0;
      a_val  = {phi_ff[53:0], 10'd0};
      b_val  = {22'd0, plo_ff[63:22]};
      ab_sum = {1'b0, a_val} + {1'b0, b_val};
      s_val  = (sat || ab_sum[64]) ? 64'hFFFF_FFFF_FFFF_FFFF : ab_sum[63:0];
      lim_val = fwd_ff ? (64'h7FFF_FFFF_FFFF_FFFF - refa_ff) : refa_ff;
   end

   always_comb begin
      state_in   = state_ff;
      refm_in    = refm_ff;    refa_in  = refa_ff;
      segm_in    = segm_ff;    segr_in  = segr_ff;  segmono_in = segmono_ff;
      cnt_in     = cnt_ff;     cur_in   = cur_ff;
      med_in     = med_ff;     resets_in = resets_ff;
      fvalid_in  = fvalid_ff;  frate_in = frate_ff;
      freal_in   = freal_ff;   fstall_in = fstall_ff;
      spos_in    = spos_ff;    spass_in = spass_ff;
      stamp_in   = stamp_ff;   cap_in   = cap_ff;  d_in = d_ff;  fwd_in = fwd_ff;
      plo_in     = plo_ff;     phi_in   = phi_ff;  mstep_in = mstep_ff;
      stall_out_in = stall_out_ff;
      taken_in   = taken_ff;
      strobe_in  = 1'b0;
      div_num    = rd;
      div_den    = md;
      dreq.start = 1'b0;
      dreq.num   = div_num;
      dreq.den   = div_den;
      for (int i = 0; i < SampleDepth; i++) begin
         samp_in[i] = samp_ff[i];
         srt_in[i]  = srt_ff[i];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
               stall_out_in = 1'b0;
               taken_in = 1'b0;
               stamp_in = 64'd0;
               cap_in   = 64'd0;
            end
         end
         ST_EVAL: begin
            state_in = ST_RESP;
            unique case (kind_ff)
               KIND_OBSERVE: begin
                  if (!drop) begin
                     taken_in = 1'b1;
                     if (rewound) resets_in = resets_ff + 32'd1;
                     refm_in = m_ff;
                     refa_in = mono_ff;
                     fstall_in = 1'b0;
                     if (new_seg) begin
                        segm_in = m_ff; segr_in = real_ff; segmono_in = mono_ff;
                        for (int i = 0; i < SampleDepth; i++) samp_in[i] = 32'd0;
                        cnt_in = '0; cur_in = '0; med_in = OneQ22;
                        fvalid_in = 1'b1; frate_in = 1'b0; freal_in = uses;
                     end else if (md >= {32'd0, interval_ff}) begin
                        segm_in = m_ff; segr_in = real_ff; segmono_in = mono_ff;
                        dreq.start = 1'b1;
                        state_in = ST_DIV;
                     end
                  end
               end
               KIND_STALL: begin
                  if (chk_stall) begin
                     fstall_in = 1'b1;
                     resets_in = resets_ff + 32'd1;
                     stall_out_in = 1'b1;
                  end
               end
               KIND_RESOLVE: begin
                  stamp_in = m_ff;
                  cap_in   = mono_ff;
                  if (fvalid_ff) begin
                     if (m_ff == 64'd0) stamp_in = refm_ff;
                     if (!refa_ff[63]) begin
                        fwd_in = ((m_ff == 64'd0) ? refm_ff : m_ff) >= refm_ff;
                        d_in = fwd_in ? ((m_ff == 64'd0) ? 64'd0 : m_ff - refm_ff)
                                      : refm_ff - m_ff;
                        mstep_in = 2'd0;
                        state_in = ST_MUL;
                     end
                  end
               end
               default: begin
                  refm_in = '0; refa_in = '0; segm_in = '0; segr_in = '0;
                  segmono_in = '0;
                  for (int i = 0; i < SampleDepth; i++) samp_in[i] = 32'd0;
                  cnt_in = '0; cur_in = '0; med_in = OneQ22;
                  fvalid_in = 1'b0; frate_in = 1'b0; freal_in = 1'b0; fstall_in = 1'b0;
                  resets_in = resets_ff + 32'd1;
               end
            endcase
         end
         ST_DIV: begin
            if (drsp.done) begin
               if (drsp.ok && drsp.quo >= minr_ff && drsp.quo <= maxr_ff) begin
                  samp_in[cur_ff] = drsp.quo;
                  cur_in = (cur_ff == IdxW'(SampleDepth - 1)) ? '0 : cur_ff + IdxW'(1);
                  if (cnt_ff < CntW'(SampleDepth)) cnt_in = cnt_ff + CntW'(1);
                  frate_in = 1'b1;
                  for (int i = 0; i < SampleDepth; i++) srt_in[i] = samp_ff[i];
                  srt_in[cur_ff] = drsp.quo;
                  spos_in = '0;
                  spass_in = '0;
                  state_in = ST_SORT;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SORT: begin
            // Bubble sort over the valid prefix, one compare a cycle.
            if ((CntW'(spos_ff) + CntW'(1)) < cnt_ff) begin
               if (srt_ff[spos_ff] > srt_ff[spos_ff + IdxW'(1)]) begin
                  srt_in[spos_ff] = srt_ff[spos_ff + IdxW'(1)];
                  srt_in[spos_ff + IdxW'(1)] = srt_ff[spos_ff];
               end
            end
            if (CntW'(spos_ff) + CntW'(2) >= cnt_ff) begin
               spos_in = '0;
               spass_in = spass_ff + CntW'(1);
               if (spass_ff + CntW'(1) >= cnt_ff) state_in = ST_MED;
            end else begin
               spos_in = spos_ff + IdxW'(1);
            end
         end
         ST_MED: begin
            if (cnt_ff[0]) med_in = s1;
            else med_in = med_sum[32:1];
            state_in = ST_RESP;
         end
         ST_MUL: begin
            // Two 32x32 products, low half first, then high half.
            if (mstep_ff == 2'd0) begin
               plo_in = {32'd0, d_ff[31:0]} * {32'd0, rate_sel} + 64'd2097152;
               mstep_in = 2'd1;
            end else begin
               phi_in = {32'd0, d_ff[63:32]} * {32'd0, rate_sel};
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (fwd_ff) cap_in = refa_ff + ((s_val > lim_val) ? lim_val : s_val);
            else cap_in = refa_ff - ((s_val > lim_val) ? lim_val : s_val);
            state_in = ST_RESP;
         end
         ST_RESP: begin
            strobe_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         reorder_ff <= 32'd50000000;
         interval_ff <= 32'd50000000;
         minr_ff <= 32'd4194;
         maxr_ff <= 32'd4194304000;
         stallto_ff <= '0;
         refm_ff <= '0; refa_ff <= '0; segm_ff <= '0; segr_ff <= '0; segmono_ff <= '0;
         for (int i = 0; i < SampleDepth; i++) samp_ff[i] <= 32'd0;
         cnt_ff <= '0; cur_ff <= '0; med_ff <= OneQ22; resets_ff <= '0;
         fvalid_ff <= 1'b0; frate_ff <= 1'b0; freal_ff <= 1'b0; fstall_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_REORDER:  reorder_ff  <= csr_wdata[31:0];
               CSR_INTERVAL: interval_ff <= csr_wdata[31:0];
               CSR_MIN_RATE: minr_ff     <= csr_wdata[31:0];
               CSR_MAX_RATE: maxr_ff     <= csr_wdata[31:0];
               CSR_STALL_TO: stallto_ff  <= csr_wdata[62:0];
               default: ;
            endcase
         end
         refm_ff <= refm_in; refa_ff <= refa_in; segm_ff <= segm_in;
         segr_ff <= segr_in; segmono_ff <= segmono_in;
         for (int i = 0; i < SampleDepth; i++) samp_ff[i] <= samp_in[i];
         cnt_ff <= cnt_in; cur_ff <= cur_in; med_ff <= med_in; resets_ff <= resets_in;
         fvalid_ff <= fvalid_in; frate_ff <= frate_in;
         freal_ff <= freal_in; fstall_ff <= fstall_in;
         strobe_ff <= strobe_in;
      end
      if (accept) begin
         kind_ff <= req_kind;
         m_ff    <= req_measurement_ns;
         real_ff <= req_sim_real_ns;
         mono_ff <= req_monotonic_ns;
      end
      for (int i = 0; i < SampleDepth; i++) srt_ff[i] <= srt_in[i];
      spos_ff <= spos_in; spass_ff <= spass_in;
      stamp_ff <= stamp_in; cap_ff <= cap_in; d_ff <= d_in; fwd_ff <= fwd_in;
      plo_ff <= plo_in; phi_ff <= phi_in; mstep_ff <= mstep_in;
      stall_out_ff <= stall_out_in; taken_ff <= taken_in;
   end

   assign rsp_strobe               = strobe_ff;
   assign rsp_stamp_measurement_ns = stamp_ff;
   assign rsp_capture_monotonic_ns = cap_ff;
   assign rsp_clock_valid          = fvalid_ff;
   assign rsp_reset_count          = resets_ff;
   assign rsp_stall_detected       = stall_out_ff;
   assign rsp_observation_taken    = taken_ff;
   assign rsp_clock_now_ns         = refm_ff;
   assign rsp_last_arrival_ns      = refa_ff;
   assign rsp_rate_q22             = med_ff;

   `MCRT_ASSERT_NEXT(a_resp_frees, clock, reset, state_ff == ST_RESP, rsp_strobe && !busy, "response did not free the unit")
   `MCRT_ASSERT_IMPL(a_stall_flag, clock, reset, rsp_stall_detected && rsp_strobe, fstall_ff, "stall reported without stall flag")
   `MCRT_ASSERT_IMPL(a_rate_one, clock, reset, !frate_ff && state_ff == ST_IDLE, med_ff == OneQ22, "median not one without samples")
endmodule
